@@ hw/rtl/smad_pkg.sv @@
// Shared types and constants of the sliding median and deviation unit.
`default_nettype none
package smad_pkg;

  // Default configuration of the storage.
  localparam int unsigned WINDOW_MAX_DEF  = 256;
  localparam int unsigned SAMPLE_BITS_DEF = 32;

  // Fixed field widths of the stream words and the register port.
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned MEDIAN_W = 32;
  localparam int unsigned COST_W   = 41;
  localparam int unsigned OUT_W    = 80;
  localparam int unsigned CFG_W    = 9;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 3;

  // Register index of the window length.
  localparam logic REG_WINDOW_SIZE = 1'b0;

  // Datapath operations issued by the sequencer.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_TAKE,
    OP_OLD_RD,
    OP_OLD_CAP,
    OP_DEL_RD,
    OP_DEL_STEP,
    OP_DEL_END,
    OP_INS_INIT,
    OP_INS_RD,
    OP_INS_STEP,
    OP_INS_ZERO,
    OP_SUM_INIT,
    OP_SUM_RD,
    OP_SUM_STEP
  } op_e;

  // Command from the sequencer.
  typedef struct packed {
    op_e  op;
    logic out_load;
  } cmd_t;

  // Status back from the datapath.
  typedef struct packed {
    logic full;
    logic idx_end;
    logic idx_zero;
    logic ins_stop;
  } stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/smad_ctrl.sv @@
// Sequencer that steps the datapath through delete, insert and sum passes.
`default_nettype none
module smad_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  input  wire             out_free_i,
  input  smad_pkg::stat_t stat_i,
  output smad_pkg::cmd_t  cmd_o
);
  import smad_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_OLD_RD, S_OLD_WT, S_DEL_RD, S_DEL_WT, S_INS_INIT,
    S_INS_RD, S_INS_WT, S_SUM_INIT, S_SUM_RD, S_SUM_WT, S_FIN
  } state_e;

  state_e state_q, state_d;

  // Next state and the operation for this cycle.
  always_comb begin
    state_d        = state_q;
    cmd_o.op       = OP_NONE;
    cmd_o.out_load = 1'b0;
    in_ready_o     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_TAKE;
          state_d  = S_OLD_RD;
        end
      end
      S_OLD_RD: begin
        if (stat_i.full) begin
          cmd_o.op = OP_OLD_RD;
          state_d  = S_OLD_WT;
        end else begin
          state_d = S_INS_INIT;
        end
      end
      S_OLD_WT: begin
        cmd_o.op = OP_OLD_CAP;
        state_d  = S_DEL_RD;
      end
      S_DEL_RD: begin
        if (stat_i.idx_end) begin
          cmd_o.op = OP_DEL_END;
          state_d  = S_INS_INIT;
        end else begin
          cmd_o.op = OP_DEL_RD;
          state_d  = S_DEL_WT;
        end
      end
      S_DEL_WT: begin
        cmd_o.op = OP_DEL_STEP;
        state_d  = S_DEL_RD;
      end
      S_INS_INIT: begin
        cmd_o.op = OP_INS_INIT;
        state_d  = S_INS_RD;
      end
      S_INS_RD: begin
        if (stat_i.idx_zero) begin
          cmd_o.op = OP_INS_ZERO;
          state_d  = S_SUM_INIT;
        end else begin
          cmd_o.op = OP_INS_RD;
          state_d  = S_INS_WT;
        end
      end
      S_INS_WT: begin
        cmd_o.op = OP_INS_STEP;
        state_d  = stat_i.ins_stop ? S_SUM_INIT : S_INS_RD;
      end
      S_SUM_INIT: begin
        cmd_o.op = OP_SUM_INIT;
        state_d  = S_SUM_RD;
      end
      S_SUM_RD: begin
        if (stat_i.idx_end) begin
          state_d = S_FIN;
        end else begin
          cmd_o.op = OP_SUM_RD;
          state_d  = S_SUM_WT;
        end
      end
      S_SUM_WT: begin
        cmd_o.op = OP_SUM_STEP;
        state_d  = S_SUM_RD;
      end
      S_FIN: begin
        if (!stat_i.full) begin
          state_d = S_IDLE;
        end else if (out_free_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/smad_dp.sv @@
// Datapath: arrival ring, sorted store, counters and half sums.
`default_nettype none
module smad_dp #(
  parameter int unsigned WINDOW_MAX  = smad_pkg::WINDOW_MAX_DEF,
  parameter int unsigned SAMPLE_BITS = smad_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned CNT_W      = $clog2(WINDOW_MAX + 1)
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  smad_pkg::cmd_t                     cmd_i,
  output smad_pkg::stat_t                    stat_o,
  input  wire                                clear_i,
  input  wire  [CNT_W-1:0]                   window_i,
  input  wire  [SAMPLE_BITS-1:0]             sample_i,
  output logic signed [SAMPLE_BITS-1:0]      median_o,
  output logic [smad_pkg::COST_W-1:0]        cost_o
);
  import smad_pkg::*;

  localparam int unsigned ADDR_W = $clog2(WINDOW_MAX);
  localparam int unsigned SUM_W  = SAMPLE_BITS + CNT_W + 1;
  localparam int unsigned DIFF_W = SUM_W + 1;
  localparam int unsigned CW     = (DIFF_W > COST_W) ? DIFF_W : COST_W;

  logic [SAMPLE_BITS-1:0] ring_mem [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0] sort_mem [WINDOW_MAX];

  logic signed [SAMPLE_BITS-1:0] v_q, d_q, med_q, srt_rd_q, ring_rd_q;
  logic [CNT_W-1:0]              n_q, idx_q;
  logic [ADDR_W-1:0]             rp_q;
  logic                          found_q;
  logic signed [SUM_W-1:0]       lsum_q, usum_q;

  logic [CNT_W:0]      old_sum;
  logic [ADDR_W-1:0]   old_addr;
  logic [ADDR_W-1:0]   srt_raddr;
  logic                srt_we;
  logic [ADDR_W-1:0]   srt_waddr;
  logic [SAMPLE_BITS-1:0] srt_wdata;
  logic                greater;
  logic [CNT_W-1:0]    idx_m1, half, mid;
  logic signed [DIFF_W-1:0] diff;
  logic signed [CW-1:0]     cost_full;

  // Slot of the oldest sample: ring pointer minus fill, modulo the ring depth.
  assign old_sum  = (CNT_W+1)'(rp_q) + (CNT_W+1)'(WINDOW_MAX) - (CNT_W+1)'(n_q);
  assign old_addr = (old_sum >= (CNT_W+1)'(WINDOW_MAX))
                    ? ADDR_W'(old_sum - (CNT_W+1)'(WINDOW_MAX)) : ADDR_W'(old_sum);

  assign idx_m1  = idx_q - CNT_W'(1);
  assign greater = srt_rd_q > v_q;
  assign half    = CNT_W'((CNT_W+1)'(n_q) + (CNT_W+1)'(1) >> 1);
  assign mid     = CNT_W'((n_q - CNT_W'(1)) >> 1);

  // Status toward the sequencer.
  assign stat_o.full     = n_q >= window_i;
  assign stat_o.idx_end  = idx_q == n_q;
  assign stat_o.idx_zero = idx_q == '0;
  assign stat_o.ins_stop = !greater;

  // Sorted store port selection.
  always_comb begin
    srt_raddr = idx_q[ADDR_W-1:0];
    if (cmd_i.op == OP_INS_RD) begin
      srt_raddr = idx_m1[ADDR_W-1:0];
    end
    srt_we    = 1'b0;
    srt_waddr = idx_q[ADDR_W-1:0];
    srt_wdata = v_q;
    unique case (cmd_i.op)
      OP_DEL_STEP: begin
        srt_we    = found_q;
        srt_waddr = idx_m1[ADDR_W-1:0];
        srt_wdata = srt_rd_q;
      end
      OP_INS_STEP: begin
        srt_we    = 1'b1;
        srt_wdata = greater ? srt_rd_q : v_q;
      end
      OP_INS_ZERO: begin
        srt_we    = 1'b1;
        srt_waddr = '0;
      end
      default: srt_we = 1'b0;
    endcase
  end

  // Memories.
  always_ff @(posedge clk_i) begin
    if (srt_we) begin
      sort_mem[srt_waddr] <= srt_wdata;
    end
    if (cmd_i.op == OP_DEL_RD || cmd_i.op == OP_INS_RD || cmd_i.op == OP_SUM_RD) begin
      srt_rd_q <= sort_mem[srt_raddr];
    end
    if (cmd_i.op == OP_INS_INIT) begin
      ring_mem[rp_q] <= v_q;
    end
    if (cmd_i.op == OP_OLD_RD) begin
      ring_rd_q <= ring_mem[old_addr];
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_TAKE:     v_q <= sample_i;
      OP_OLD_CAP:  d_q <= ring_rd_q;
      OP_SUM_INIT: begin
        lsum_q <= '0;
        usum_q <= '0;
      end
      OP_SUM_STEP: begin
        if (idx_q < half) begin
          lsum_q <= lsum_q + SUM_W'(srt_rd_q);
        end else begin
          usum_q <= usum_q + SUM_W'(srt_rd_q);
        end
        if (idx_q == mid) begin
          med_q <= srt_rd_q;
        end
      end
      default: ;
    endcase
  end

  // Counters and the delete match flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q     <= '0;
      rp_q    <= '0;
      idx_q   <= '0;
      found_q <= 1'b0;
    end else if (clear_i) begin
      n_q  <= '0;
      rp_q <= '0;
    end else begin
      unique case (cmd_i.op)
        OP_OLD_CAP: begin
          idx_q   <= '0;
          found_q <= 1'b0;
        end
        OP_DEL_STEP: begin
          if (!found_q && srt_rd_q == d_q) begin
            found_q <= 1'b1;
          end
          idx_q <= idx_q + CNT_W'(1);
        end
        OP_DEL_END: n_q <= n_q - CNT_W'(1);
        OP_INS_INIT: begin
          idx_q <= n_q;
          rp_q  <= (rp_q == ADDR_W'(WINDOW_MAX - 1)) ? '0 : rp_q + ADDR_W'(1);
        end
        OP_INS_STEP: begin
          if (greater) begin
            idx_q <= idx_m1;
          end else begin
            n_q <= n_q + CNT_W'(1);
          end
        end
        OP_INS_ZERO: n_q <= n_q + CNT_W'(1);
        OP_SUM_INIT: idx_q <= '0;
        OP_SUM_STEP: idx_q <= idx_q + CNT_W'(1);
        default: ;
      endcase
    end
  end

  // Cost: upper sum minus lower sum, plus the median for an odd fill.
  assign diff = DIFF_W'(usum_q) - DIFF_W'(lsum_q) + (n_q[0] ? DIFF_W'(med_q) : '0);
  assign cost_full = CW'(diff);
  assign cost_o    = cost_full[COST_W-1:0];
  assign median_o  = med_q;

endmodule
`default_nettype wire

@@ hw/rtl/sliding_median_abs_deviation_unit.sv @@
// Top level: register port, stream ports, sequencer and datapath.
`default_nettype none
// Sliding-window median and absolute-deviation cost. Each sample word on the
// slave stream enters a window of the last window_size samples (register 0,
// 1 to WINDOW_MAX, written at byte address 0; a write to it empties the window).
// Once the window is full, every sample yields one master word with the lower
// median and the sum of absolute deviations from it. The window is held in a
// single-port sorted memory, so one sample takes a delete pass, an insertion
// pass and a summing pass, each with a read state and a wait state per entry
// touched; the unit takes one sample at a time.
module sliding_median_abs_deviation_unit #(
  parameter int unsigned WINDOW_MAX  = smad_pkg::WINDOW_MAX_DEF,
  parameter int unsigned SAMPLE_BITS = smad_pkg::SAMPLE_BITS_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire  [smad_pkg::SAMPLE_W-1:0]  s_axis_tdata,   // [31:0] sample
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  output logic [smad_pkg::OUT_W-1:0]     m_axis_tdata,   // [31:0] median, [72:32] cost
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [smad_pkg::APB_AW-1:0]    paddr,
  input  wire  [smad_pkg::APB_DW-1:0]    pwdata,
  output logic [smad_pkg::APB_DW-1:0]    prdata,
  output logic                           pready
);
  import smad_pkg::*;

  localparam int unsigned CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int unsigned WW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CNT_W-1:0] window_q, window_d;
  logic             cfg_wr;
  logic [WW-1:0]    wr_val;
  logic             out_valid_q;
  logic [MEDIAN_W-1:0] med_out_q;
  logic [COST_W-1:0]   cost_out_q;
  cmd_t             cmd;
  stat_t            stat;
  logic signed [SAMPLE_BITS-1:0] median;
  logic [COST_W-1:0] cost;
  logic             out_free;

  // Register port: window length, clamped to the legal range.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW_SIZE);
  assign wr_val = WW'(pwdata[CFG_W-1:0]);
  always_comb begin
    if (wr_val == '0) begin
      window_d = CNT_W'(1);
    end else if (wr_val > WW'(WINDOW_MAX)) begin
      window_d = CNT_W'(WINDOW_MAX);
    end else begin
      window_d = wr_val[CNT_W-1:0];
    end
  end
  assign prdata = (paddr[2] == REG_WINDOW_SIZE) ? APB_DW'(window_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= CNT_W'(1);
    end else if (cfg_wr) begin
      window_q <= window_d;
    end
  end

  // Output word register.
  assign out_free = !out_valid_q || m_axis_tready;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      med_out_q  <= MEDIAN_W'(median);
      cost_out_q <= cost;
    end
  end
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_W - MEDIAN_W - COST_W)'(0), cost_out_q, med_out_q};

  smad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  smad_dp #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .clear_i  (cfg_wr),
    .window_i (window_q),
    .sample_i (s_axis_tdata[SAMPLE_BITS-1:0]),
    .median_o (median),
    .cost_o   (cost)
  );

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
// Stream testbench for the sliding-window median and absolute-deviation unit.
`timescale 1ns / 1ps
module testbench;
  import smad_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  wire                 s_axis_tready;
  logic [SAMPLE_W-1:0] s_axis_tdata = '0;
  wire                 m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  wire  [OUT_W-1:0]    m_axis_tdata;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  wire  [APB_DW-1:0]   prdata;
  wire                 pready;

  sliding_median_abs_deviation_unit dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Predictor state: the window in arrival order and sorted order.
  int unsigned       win_len;
  logic signed [31:0] ring_q[$];
  logic signed [31:0] sorted_q[$];

  typedef struct packed {
    logic [COST_W-1:0]   cost;
    logic [MEDIAN_W-1:0] median;
  } result_t;

  result_t     pending_results[$];
  logic [31:0] sample_queue[$];
  int          errors = 0;
  int          samples_sent = 0;
  int          results_seen = 0;

  function automatic int unsigned clamp_window(logic [31:0] value);
    logic [8:0] w;
    w = value[8:0];
    if (w == 0) return 1;
    if (w > 256) return 256;
    return w;
  endfunction

  // Slide one sample through the window and queue the result if it is full.
  task automatic predict_sample(logic signed [31:0] s);
    int pos;
    int half;
    logic signed [31:0] oldest;
    logic signed [47:0] lo_sum;
    logic signed [47:0] hi_sum;
    logic signed [47:0] cost;
    result_t r;
    if (ring_q.size() >= win_len) begin
      oldest = ring_q.pop_front();
      foreach (sorted_q[i]) begin
        if (sorted_q[i] == oldest) begin
          sorted_q.delete(i);
          break;
        end
      end
    end
    ring_q.push_back(s);
    pos = 0;
    while (pos < sorted_q.size() && sorted_q[pos] <= s) pos++;
    sorted_q.insert(pos, s);
    if (sorted_q.size() < win_len) return;
    half = (sorted_q.size() + 1) / 2;
    lo_sum = 0;
    hi_sum = 0;
    foreach (sorted_q[i]) begin
      if (i < half) lo_sum += sorted_q[i];
      else hi_sum += sorted_q[i];
    end
    cost = hi_sum - lo_sum;
    if (sorted_q.size() % 2 == 1) cost += sorted_q[half - 1];
    r.median = sorted_q[half - 1];
    r.cost = cost[COST_W-1:0];
    pending_results.push_back(r);
  endtask

  // Write the window length over the register port while the unit is idle.
  task automatic write_window(logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {REG_WINDOW_SIZE, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata[8:0] != clamp_window(value)) begin
      $display("%0t window readback expected %0d actual %0d", $time,
               clamp_window(value), prdata[8:0]);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    win_len = clamp_window(value);
    ring_q.delete();
    sorted_q.delete();
  endtask

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return $urandom_range(1, 3);
  endfunction

  // Block until the queue is drained and every result has come.
  task automatic drain(int unsigned latency);
    while (sample_queue.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (latency) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_sample(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 15) - 8;
      default: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_fff0}
                      + $urandom_range(0, 15);
    endcase
  endfunction

  // Handshake seen at the rising edge, used by the driver at the next falling edge.
  logic s_axis_tready_q = 1'b0;

  // Sample driver: one word per handshake, random gaps in between.
  int unsigned send_gap = 0;
  always @(negedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready_q) begin
      samples_sent++;
    end
    if (!s_axis_tvalid || s_axis_tready_q) begin
      if (send_gap != 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (sample_queue.size() != 0) begin
        s_axis_tdata <= sample_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        send_gap = gap_len();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // The predictor runs on acceptance.
  always @(posedge clk_i) begin
    s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) predict_sample(s_axis_tdata);
  end

  // Result monitor and random backpressure on the master side.
  int unsigned stall_len = 0;
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[MEDIAN_W+COST_W-1:0];
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected word median %0d cost %0d", $time,
                 $signed(got.median), got.cost);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.median != want.median) begin
          $display("%0t median expected %0d actual %0d", $time,
                   $signed(want.median), $signed(got.median));
          errors++;
        end
        if (got.cost != want.cost) begin
          $display("%0t cost expected %0d actual %0d", $time, want.cost, got.cost);
          errors++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_len != 0) begin
      stall_len--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      stall_len = gap_len();
    end
  end

  // Stimulus: directed corners, then random phases at several window lengths.
  initial begin
    int unsigned sizes[8];
    int unsigned lat;
    win_len = 1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // Reset length of one: each sample is its own median with zero cost.
    sample_queue.push_back(32'h8000_0000);
    sample_queue.push_back(32'h7fff_ffff);
    sample_queue.push_back(32'h0);
    drain(20);
    // Zero is taken as one; extremes, equal samples and a large spread.
    write_window(0);
    sample_queue.push_back(32'hffff_ffff);
    sample_queue.push_back(32'h5555_5555);
    drain(20);
    write_window(4);
    sample_queue.push_back(32'h8000_0000);
    sample_queue.push_back(32'h7fff_ffff);
    sample_queue.push_back(32'h8000_0000);
    sample_queue.push_back(32'h7fff_ffff);
    sample_queue.push_back(32'h7fff_ffff);
    sample_queue.push_back(32'haaaa_aaaa);
    sample_queue.push_back(32'h5555_5555);
    drain(60);
    write_window(3);
    repeat (6) sample_queue.push_back(32'h0000_0007);
    sample_queue.push_back(32'hffff_fffe);
    drain(60);
    // Lengths above the limit saturate; only the low nine bits of a write are taken.
    write_window(32'h1ff);
    repeat (270) sample_queue.push_back(rand_sample(0));
    drain(6 * 256 + 40);
    write_window(32'hffff_fe05);
    sizes = '{1, 2, 3, 5, 8, 16, 33, 256};
    for (int ph = 0; ph < 8; ph++) begin
      win_len = sizes[$urandom_range(0, 6)];
      write_window(win_len);
      lat = 6 * win_len + 40;
      repeat (win_len + 30) sample_queue.push_back(rand_sample($urandom_range(0, 2)));
      drain(lat);
    end
    $display("Covered %0d samples and %0d results over window lengths 1 to 256,",
             samples_sent, results_seen);
    $display("with extreme, repeated and random samples under random stalls.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule

@@ sliding_median_abs_deviation_unit.f @@
hw/rtl/smad_pkg.sv
hw/rtl/smad_ctrl.sv
hw/rtl/smad_dp.sv
hw/rtl/sliding_median_abs_deviation_unit.sv
bench/testbench.sv
